// File: rtl/iecc_pkg.sv
// Shared types, constants and ones'-complement helpers for the ICMP echo
// checksum checker. No dependencies; every other file imports this package.
package iecc_pkg;

   // Input transaction payload
   typedef struct packed {
      logic [63:0] in_data;
      logic [7:0]  in_keep;
      logic        in_last;
   } req_payload_type;

   // Result transaction payload
   typedef struct packed {
      logic        result_kind;
      logic [63:0] out_data;
      logic [7:0]  out_keep;
      logic        out_last;
      logic        keep_packet;
      logic [15:0] reply_checksum;
      logic        run_end;
   } rsp_payload_type;

   // Result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Word positions inside a packet
   localparam int unsigned WIDX_W = 7;
   localparam logic [WIDX_W-1:0] WORD_FIRST  = 7'd0;
   localparam logic [WIDX_W-1:0] WORD_SECOND = 7'd1;
   localparam logic [WIDX_W-1:0] WORD_ICMP   = 7'd2;
   localparam logic [WIDX_W-1:0] WORD_MAX    = 7'd127;

   // ICMP codes
   localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
   localparam logic [7:0]  ECHO_REPLY_TYPE   = 8'd0;
   localparam logic [7:0]  ECHO_CODE         = 8'd0;
   localparam logic [15:0] TYPE_CODE_DELTA   = 16'h0800;
   localparam logic [15:0] ALL_ONES16        = 16'hFFFF;

   // Result queue sizing
   localparam int unsigned Q_DEPTH    = 4;
   localparam int unsigned Q_CNT_W    = 3;
   localparam int unsigned MAX_PUSH   = 3;
   localparam int unsigned PUSH_CNT_W = 2;

   // 16-bit ones'-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

   // Byte pair of one lane in network order
   function automatic logic [15:0] lane_value(input logic [15:0] pair);
      return {pair[7:0], pair[15:8]};
   endfunction

endpackage

// File: rtl/iecc_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on iecc_pkg for the payload types.
interface iecc_req_if;
   import iecc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface iecc_rsp_if;
   import iecc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/iecc_rsp_queue.sv
// Small shifting result queue: takes up to three results per cycle, hands
// out one per cycle on ready from a registered head. Depends on iecc_pkg.
module iecc_rsp_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [iecc_pkg::PUSH_CNT_W-1:0]         push_n,
   input  iecc_pkg::rsp_payload_type               push_data [0:iecc_pkg::MAX_PUSH-1],
   output logic                                    has_room,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output iecc_pkg::rsp_payload_type               out_data
);
   import iecc_pkg::*;

   rsp_payload_type         slot_ff  [0:Q_DEPTH-1];
   rsp_payload_type         slot_in  [0:Q_DEPTH-1];
   rsp_payload_type         shifted  [0:Q_DEPTH-1];
   logic [Q_CNT_W-1:0]      count_ff;
   logic [Q_CNT_W-1:0]      count_in;
   logic [Q_CNT_W-1:0]      after_pop;
   logic [Q_CNT_W-1:0]      rel;
   logic                    pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[0];
   // room for a full burst of results
   assign has_room  = (count_ff <= Q_CNT_W'(Q_DEPTH - MAX_PUSH));

   // queue contents after a pop and the new pushes
   always_comb begin
      pop       = out_valid && out_ready;
      after_pop = count_ff - {{(Q_CNT_W-1){1'b0}}, pop};
      count_in  = after_pop + {{(Q_CNT_W-PUSH_CNT_W){1'b0}}, push_n};
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
         shifted[i] = slot_ff[i+1];
      end
      shifted[Q_DEPTH-1] = slot_ff[Q_DEPTH-1];
      for (int i = 0; i < Q_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         rel        = Q_CNT_W'(i) - after_pop;
         if (Q_CNT_W'(i) < after_pop) begin
            if (pop) begin
               slot_in[i] = shifted[i];
            end
         end else if (rel < {{(Q_CNT_W-PUSH_CNT_W){1'b0}}, push_n}) begin
            slot_in[i] = push_data[rel[PUSH_CNT_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

// File: rtl/icmp_echo_checksum_checker.sv
// ICMP echo checksum checker: forwards a packet one word late, rewritten
// toward an echo reply, and ends it with a keep/drop verdict.
// Words pass an input register; results leave a 4-entry queue's registered head.
// Throughput: one word per cycle; input waits while the queue lacks room. A last
// word yields up to three results, leaving one per cycle while rsp_chan is ready.
// Reset (synchronous) clears the word counter, the input stage and the queue.
module icmp_echo_checksum_checker (
   input logic        clock,
   input logic        reset,
   iecc_req_if.sink   req_chan,
   iecc_rsp_if.source rsp_chan
);
   import iecc_pkg::*;

   // input stage
   logic                in_valid_ff;
   req_payload_type     in_ff;
   logic                proc_fire;
   logic                q_room;

   // packet state
   logic [WIDX_W-1:0]   word_index_ff, word_index_in;
   logic [63:0]         held_data_ff, held_data_in;
   logic [7:0]          held_keep_ff;
   logic                held_last_ff;
   logic [15:0]         lane_ff [0:3];
   logic [15:0]         lane_in [0:3];
   logic [15:0]         rx_csum_ff, rx_csum_in;
   logic [7:0]          msg_type_ff, msg_type_in;
   logic [7:0]          msg_code_ff, msg_code_in;

   // per-item combinational results
   logic [15:0]         addend [0:3];
   logic [1:0]          pair;
   logic [63:0]         cur;
   logic [17:0]         total;
   logic [16:0]         fold1;
   logic [16:0]         fold2;
   logic                echo;
   logic                kp;
   logic [15:0]         hc;
   rsp_payload_type     ent_fwd, ent_held, ent_verdict;
   rsp_payload_type     push_data [0:MAX_PUSH-1];
   logic [PUSH_CNT_W-1:0] push_n;
   logic                is_first;

   assign proc_fire      = in_valid_ff && q_room;
   assign req_chan.ready = !in_valid_ff || proc_fire;
   assign cur            = in_ff.in_data;
   assign is_first       = (word_index_ff == WORD_FIRST);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (proc_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff <= req_chan.payload;
      end
   end

   // lane sums, header capture and rewritten held word
   always_comb begin
      held_data_in = cur;
      rx_csum_in   = rx_csum_ff;
      msg_type_in  = msg_type_ff;
      msg_code_in  = msg_code_ff;
      ent_fwd      = '0;
      ent_fwd.result_kind = KIND_DATA;
      ent_fwd.out_data    = held_data_ff;
      ent_fwd.out_keep    = held_keep_ff;
      ent_fwd.out_last    = held_last_ff;
      for (int i = 0; i < 4; i++) begin
         addend[i] = '0;
      end
      pair = '0;
      unique case (word_index_ff)
         WORD_FIRST: begin
         end
         WORD_SECOND: begin
         end
         WORD_ICMP: begin
            msg_type_in = cur[39:32];
            msg_code_in = cur[47:40];
            rx_csum_in  = lane_value(cur[63:48]);
            ent_fwd.out_data = {cur[31:0], held_data_ff[31:0]};
            ent_fwd.out_keep = 8'hFF;
            ent_fwd.out_last = 1'b0;
            addend[2] = lane_value(cur[47:32]);
            addend[3] = lane_value(cur[63:48]);
            held_data_in = {cur[63:40], ECHO_REPLY_TYPE, held_data_ff[63:32]};
         end
         default: begin
            for (int i = 0; i < 4; i++) begin
               pair = in_ff.in_keep[2*i +: 2];
               if (pair == 2'b11) begin
                  addend[i] = lane_value(cur[16*i +: 16]);
               end else if (pair[0]) begin
                  addend[i] = {cur[16*i +: 8], 8'h00};
               end
            end
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         lane_in[i] = is_first ? 16'h0000 : oc_add(lane_ff[i], addend[i]);
      end
   end

   // verdict: fold the four lanes, check type/code, update checksum
   always_comb begin
      total = {2'b00, lane_in[0]} + {2'b00, lane_in[1]}
            + {2'b00, lane_in[2]} + {2'b00, lane_in[3]};
      fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
      fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
      echo  = (msg_type_in == ECHO_REQUEST_TYPE) && (msg_code_in == ECHO_CODE);
      hc    = echo ? oc_add(~rx_csum_in, ~TYPE_CODE_DELTA) : ~rx_csum_in;
      hc    = ~hc;
      kp    = (fold2[15:0] == ALL_ONES16) && echo;

      ent_held             = '0;
      ent_held.result_kind = KIND_DATA;
      ent_held.out_data    = held_data_in;
      ent_held.out_keep    = in_ff.in_keep;
      ent_held.out_last    = in_ff.in_last;

      ent_verdict                = '0;
      ent_verdict.result_kind    = KIND_VERDICT;
      ent_verdict.keep_packet    = kp;
      ent_verdict.reply_checksum = kp ? hc : 16'h0000;
      ent_verdict.run_end        = 1'b1;
   end

   // results caused by this word, in order
   always_comb begin
      for (int k = 0; k < MAX_PUSH; k++) begin
         push_data[k] = ent_verdict;
      end
      push_n = '0;
      if (in_ff.in_last) begin
         if (is_first) begin
            push_data[0] = ent_held;
            push_n       = PUSH_CNT_W'(2);
         end else begin
            push_data[0] = ent_fwd;
            push_data[1] = ent_held;
            push_n       = PUSH_CNT_W'(3);
         end
      end else if (!is_first) begin
         push_data[0]         = ent_fwd;
         push_data[0].run_end = 1'b1;
         push_n               = PUSH_CNT_W'(1);
      end
      if (!proc_fire) begin
         push_n = '0;
      end
   end

   // word counter
   always_comb begin
      if (in_ff.in_last) begin
         word_index_in = WORD_FIRST;
      end else if (word_index_ff < WORD_MAX) begin
         word_index_in = word_index_ff + 7'd1;
      end else begin
         word_index_in = word_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff <= WORD_FIRST;
      end else if (proc_fire) begin
         word_index_ff <= word_index_in;
      end
   end

   // packet state registers
   always_ff @(posedge clock) begin
      if (proc_fire) begin
         held_data_ff <= held_data_in;
         held_keep_ff <= in_ff.in_keep;
         held_last_ff <= in_ff.in_last;
         rx_csum_ff   <= rx_csum_in;
         msg_type_ff  <= msg_type_in;
         msg_code_ff  <= msg_code_in;
         for (int i = 0; i < 4; i++) begin
            lane_ff[i] <= lane_in[i];
         end
      end
   end

   iecc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_data (push_data),
      .has_room  (q_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.payload)
   );

endmodule

// File: verif/icmp_echo_checksum_checker_tb.sv
// Self-checking testbench for icmp_echo_checksum_checker: drives packets over the
// request channel and checks every result transaction against an in-bench predictor.
// Depends on iecc_pkg, iecc_if and the checker RTL.
module icmp_echo_checksum_checker_tb;
   import iecc_pkg::*;

   logic clock = 1'b0;
   logic reset;

   iecc_req_if req_chan ();
   iecc_rsp_if rsp_chan ();

   icmp_echo_checksum_checker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Idle rates in percent for each side
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned fault_count;

   // Expected result transactions, oldest first
   rsp_payload_type due_results[$];

   // Packet under construction
   logic [63:0] pkt_data[$];
   logic [7:0]  pkt_keep[$];

   // Predictor state
   logic [WIDX_W-1:0] word_pos;
   logic [63:0]       hold_word;
   logic [7:0]        hold_keep;
   logic              hold_last;
   logic [15:0]       lane_acc[4];
   logic [15:0]       seen_csum;
   logic [7:0]        seen_type;
   logic [7:0]        seen_code;

   // Monitor scratch
   rsp_payload_type seen_rsp;
   rsp_payload_type due_rsp;

   // Ones'-complement 16-bit sum with end-around carry
   function automatic logic [15:0] ones_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] raw;
      raw = {1'b0, a} + {1'b0, b};
      return raw[15:0] + {15'd0, raw[16]};
   endfunction

   // Two bytes of one lane, first byte high (network order)
   function automatic logic [15:0] net16(input logic [63:0] w, input int lane);
      return {w[16*lane +: 8], w[16*lane+8 +: 8]};
   endfunction

   // Contribution of one lane of a payload word under its keep mask
   function automatic logic [15:0] lane_term(input logic [63:0] w, input logic [7:0] k,
                                             input int lane);
      logic [1:0] pair;
      pair = k[2*lane +: 2];
      if (pair == 2'b11)
         return net16(w, lane);
      else if (pair[0])
         return {w[16*lane +: 8], 8'h00};
      return 16'h0000;
   endfunction

   function automatic rsp_payload_type data_rsp(input logic [63:0] d, input logic [7:0] k,
                                                input logic l);
      rsp_payload_type r;
      r = '0;
      r.result_kind = KIND_DATA;
      r.out_data    = d;
      r.out_keep    = k;
      r.out_last    = l;
      return r;
   endfunction

   // Predict the results caused by one accepted request transaction
   task automatic predict_echo_word(input logic [63:0] d, input logic [7:0] k, input logic l);
      rsp_payload_type batch[$];
      rsp_payload_type verdict;
      logic [63:0]     cur;
      logic [15:0]     total;
      logic [15:0]     upd;
      logic            is_echo;
      logic            keep_it;
      cur = d;
      if (word_pos == WORD_FIRST) begin
         for (int i = 0; i < 4; i++) lane_acc[i] = 16'h0000;
      end else if (word_pos == WORD_SECOND) begin
         batch.push_back(data_rsp(hold_word, hold_keep, hold_last));
      end else if (word_pos == WORD_ICMP) begin
         seen_type = d[39:32];
         seen_code = d[47:40];
         seen_csum = net16(d, 3);
         // word 1 leaves with the destination address as its source
         batch.push_back(data_rsp({d[31:0], hold_word[31:0]}, 8'hFF, 1'b0));
         lane_acc[2] = ones_add16(lane_acc[2], net16(d, 2));
         lane_acc[3] = ones_add16(lane_acc[3], net16(d, 3));
         cur = {d[63:40], ECHO_REPLY_TYPE, hold_word[63:32]};
      end else begin
         for (int i = 0; i < 4; i++) lane_acc[i] = ones_add16(lane_acc[i], lane_term(d, k, i));
         batch.push_back(data_rsp(hold_word, hold_keep, hold_last));
      end
      hold_word = cur;
      hold_keep = k;
      hold_last = l;
      if (word_pos != WORD_MAX) word_pos = word_pos + 1'b1;

      // End of packet: flush the held word, then the verdict
      if (l) begin
         word_pos = WORD_FIRST;
         batch.push_back(data_rsp(hold_word, hold_keep, hold_last));
         total = ones_add16(ones_add16(lane_acc[0], lane_acc[2]),
                            ones_add16(lane_acc[1], lane_acc[3]));
         is_echo = (seen_type == ECHO_REQUEST_TYPE) && (seen_code == ECHO_CODE);
         upd = ~seen_csum;
         if (is_echo) upd = ones_add16(upd, ~TYPE_CODE_DELTA);
         upd = ~upd;
         keep_it = (total == ALL_ONES16) && is_echo;
         verdict = '0;
         verdict.result_kind    = KIND_VERDICT;
         verdict.keep_packet    = keep_it;
         verdict.reply_checksum = keep_it ? upd : 16'h0000;
         batch.push_back(verdict);
      end

      if (batch.size() > 0) batch[batch.size()-1].run_end = 1'b1;
      foreach (batch[i]) due_results.push_back(batch[i]);
   endtask

   // Send one word; returns at the accepting edge
   task automatic send_word(input logic [63:0] d, input logic [7:0] k, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{in_data: d, in_keep: k, in_last: l};
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      predict_echo_word(d, k, l);
   endtask

   task automatic send_packet();
      foreach (pkt_data[i]) send_word(pkt_data[i], pkt_keep[i], i == pkt_data.size() - 1);
   endtask

   // Random packet; tail_bytes sets the keep of a last word beyond word 2
   task automatic build_packet(input int n_words, input int tail_bytes,
                               input logic [7:0] icmp_type, input logic [7:0] icmp_code);
      logic [63:0] w;
      pkt_data.delete();
      pkt_keep.delete();
      for (int i = 0; i < n_words; i++) begin
         w = {$urandom, $urandom};
         if (i == 2) w[63:32] = {16'h0000, icmp_code, icmp_type};
         pkt_data.push_back(w);
         if (i == n_words - 1 && i > 2)
            pkt_keep.push_back(8'hFF >> (8 - tail_bytes));
         else
            pkt_keep.push_back(8'hFF);
      end
   endtask

   // Fill in the ICMP checksum so the packet verifies under its current keeps
   task automatic seal_packet();
      logic [15:0] acc;
      logic [15:0] cs;
      logic [63:0] w;
      w = pkt_data[2];
      w[63:48] = 16'h0000;
      acc = ones_add16(net16(w, 2), 16'h0000);
      for (int i = 3; i < pkt_data.size(); i++)
         for (int j = 0; j < 4; j++) acc = ones_add16(acc, lane_term(pkt_data[i], pkt_keep[i], j));
      cs = ~acc;
      w[55:48] = cs[15:8];
      w[63:56] = cs[7:0];
      pkt_data[2] = w;
   endtask

   // Hold the request side off until every expected result has arrived
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Field-by-field comparison
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fault_count++;
      end
   endtask

   // Directed packets: minimal, odd tail, bad checksum, wrong type/code, extremes, short
   task automatic test_directed_cases();
      logic [63:0] w;
      // minimal three-word echo request, first packet so the ICMP fields are set
      build_packet(3, 8, ECHO_REQUEST_TYPE, ECHO_CODE);
      seal_packet();
      send_packet();
      // odd trailing byte and a low-byte-only keep mid packet
      build_packet(5, 3, ECHO_REQUEST_TYPE, ECHO_CODE);
      pkt_keep[3] = 8'h55;
      seal_packet();
      send_packet();
      // bad checksum, last word with only high keep bits
      build_packet(4, 8, ECHO_REQUEST_TYPE, ECHO_CODE);
      pkt_keep[3] = 8'hAA;
      seal_packet();
      w = pkt_data[2];
      w[56] = ~w[56];
      pkt_data[2] = w;
      send_packet();
      // valid checksum, but echo reply type, then nonzero code
      build_packet(3, 8, ECHO_REPLY_TYPE, ECHO_CODE);
      seal_packet();
      send_packet();
      build_packet(3, 8, ECHO_REQUEST_TYPE, 8'd1);
      seal_packet();
      send_packet();
      // all ones
      build_packet(3, 8, 8'hFF, 8'hFF);
      foreach (pkt_data[i]) pkt_data[i] = '1;
      send_packet();
      // all zeros, empty last keep
      build_packet(4, 8, 8'h00, 8'h00);
      foreach (pkt_data[i]) pkt_data[i] = '0;
      pkt_keep[3] = 8'h00;
      send_packet();
      // short packets reuse the previous ICMP fields
      send_word({$urandom, $urandom}, 8'($urandom), 1'b1);
      build_packet(2, 8, 8'h00, 8'h00);
      pkt_keep[1] = 8'($urandom);
      send_packet();
   endtask

   // Long packet: the word counter must stop, not wrap and clear the sums
   task automatic test_word_counter_saturation();
      drain_results();
      build_packet(130, 5, ECHO_REQUEST_TYPE, ECHO_CODE);
      seal_packet();
      send_packet();
   endtask

   // Mostly well-formed packets with random content, the rest noise
   task automatic test_random_traffic();
      int sent;
      int n;
      logic [7:0] t;
      logic [7:0] c;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 32; recv_idle_pct = 64; end
            1: begin send_idle_pct = 64; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         sent = 0;
         while (sent < 6) begin
            if ($urandom_range(3) != 0) begin
               n = $urandom_range(3, 12);
               t = ECHO_REQUEST_TYPE;
               c = ECHO_CODE;
               if ($urandom_range(9) == 0) begin
                  t = 8'($urandom);
                  c = 8'($urandom_range(1));
               end
               build_packet(n, $urandom_range(1, 8), t, c);
               if ($urandom_range(9) != 0) seal_packet();
            end else begin
               n = $urandom_range(1, 10);
               build_packet(n, 8, 8'($urandom), 8'($urandom));
               foreach (pkt_keep[i]) pkt_keep[i] = 8'($urandom);
               if (n > 2 && $urandom_range(1) == 0) seal_packet();
            end
            send_packet();
            sent += n;
         end
      end
   endtask

   // Receiver: ready toggles at random per the current idle rate
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result monitor: a transaction seen at the falling edge completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_rsp = rsp_chan.payload;
         if (due_results.size() == 0) begin
            $error("unexpected result transaction %h", seen_rsp);
            fault_count++;
         end else begin
            due_rsp = due_results.pop_front();
            check_field("result_kind", due_rsp.result_kind, seen_rsp.result_kind);
            check_field("out_data", due_rsp.out_data, seen_rsp.out_data);
            check_field("out_keep", due_rsp.out_keep, seen_rsp.out_keep);
            check_field("out_last", due_rsp.out_last, seen_rsp.out_last);
            check_field("keep_packet", due_rsp.keep_packet, seen_rsp.keep_packet);
            check_field("reply_checksum", due_rsp.reply_checksum, seen_rsp.reply_checksum);
            check_field("run_end", due_rsp.run_end, seen_rsp.run_end);
         end
      end
   end

   // Main sequence
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      send_idle_pct = 32;
      recv_idle_pct = 64;
      fault_count = 0;
      word_pos = WORD_FIRST;
      hold_word = '0;
      hold_keep = '0;
      hold_last = 1'b0;
      for (int i = 0; i < 4; i++) lane_acc[i] = 16'h0000;
      seen_csum = '0;
      seen_type = '0;
      seen_code = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_word_counter_saturation();
      test_random_traffic();

      drain_results();
      repeat (16) @(posedge clock);
      if (fault_count == 0)
         $display("icmp_echo_checksum_checker: match");
      else
         $display("icmp_echo_checksum_checker: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("icmp_echo_checksum_checker: mismatch");
      $finish;
   end

endmodule

// File: sim.f
rtl/iecc_pkg.sv
rtl/iecc_if.sv
rtl/iecc_rsp_queue.sv
rtl/icmp_echo_checksum_checker.sv
verif/icmp_echo_checksum_checker_tb.sv
